@@ rtl/art_pkg.sv @@
// shared types and codes for the address resolution table
package art_pkg;

    localparam logic [1:0] CMD_ADD          = 2'd0;
    localparam logic [1:0] CMD_LOOKUP_ADDR  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP_INDEX = 2'd2;
    localparam logic [1:0] CMD_REMOVE       = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [7:0]  node_address;
        logic [47:0] dest_mac;
        logic [47:0] iface_mac;
        logic [7:0]  iface_index;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/address_resolution_table.sv @@
// address resolution table top level: command sequencer around one entry ram
//
// usage: one command beat enters on the input channel (in_valid / in_ready)
// and exactly one result beat leaves on the output channel (out_valid /
// out_ready). commands are add, lookup by node address, lookup by interface
// index and remove. entries are kept dense in slots 0 .. count-1.
// sequencing: one command at a time. an add, full table or not, goes straight
// to its result without reading the ram. a lookup reads one slot per cycle
// from the entry ram (one read port, registered read) and stops at the first
// hit, or answers not found once every slot below the count is read. remove
// scans the same way, then after a hit moves each later entry one slot forward
// at one entry per cycle (read slot j, write slot j-1 on the ram write port).
// the next command beat can be taken in the cycle after a result is loaded, so
// the command rate is set by the scan over the ram port and by the receiver,
// since a stalled receiver holds a finished result in the done state.
// reset clears the entry count, the sequencer state and the valid flags; ram
// contents are not cleared, since only slots below the count are ever read.
// a finished result sits in the output register; while the receiver stalls
// a new command may still be taken and worked on, and its result waits in
// a staging register until the output register frees up.
module address_resolution_table
    import art_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  node_address,
    input  logic [47:0] dest_mac,
    input  logic [47:0] iface_mac,
    input  logic [7:0]  iface_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  hit_address,
    output logic [47:0] hit_dest_mac,
    output logic [47:0] hit_iface_mac,
    output logic [7:0]  hit_iface_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;          // next slot to read
    logic          pend_reg, pend_next;        // read data valid this cycle
    logic [CW-1:0] pend_idx_reg, pend_idx_next; // slot of pending read data
    logic [1:0]    cmd_reg, cmd_next;
    logic [7:0]    key_reg, key_next;

    logic [1:0]    res_status_reg, res_status_next;
    entry_t        res_entry_reg, res_entry_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    entry_t        out_entry_reg, out_entry_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_word;
    entry_t        rd_entry;
    logic          rd_match;
    logic [CW-1:0] shift_dst;

    art_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry  = entry_t'(rd_word);
    assign rd_match  = (cmd_reg == CMD_LOOKUP_INDEX) ? (rd_entry.iface_index == key_reg)
                                                     : (rd_entry.node_address == key_reg);
    assign shift_dst = pend_idx_reg - CW'(1);
    assign rd_addr   = ptr_reg[AW-1:0];

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pend_next       = 1'b0;
        pend_idx_next   = ptr_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = '{node_address, dest_mac, iface_mac, iface_index};
        rd_en           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = command;
                    key_next       = (command == CMD_LOOKUP_INDEX) ? iface_index : node_address;
                    res_entry_next = '0;
                    ptr_next       = '0;
                    if (command == CMD_ADD)
                    begin
                        state_next = S_DONE;
                        if (count_reg == FULL_COUNT)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            // append at the first free slot
                            wr_en           = 1'b1;
                            count_next      = count_reg + CW'(1);
                            res_status_next = STATUS_OK;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (pend_reg && rd_match)
                begin
                    res_status_next = STATUS_OK;
                    res_entry_next  = rd_entry;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        // close the gap starting with the slot after the hit
                        ptr_next   = pend_idx_reg + CW'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    ptr_next  = ptr_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    res_status_next = STATUS_NOT_FOUND;
                    res_entry_next  = '0;
                    state_next      = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // read slot j while slot j-2 takes the data of slot j-1, read last cycle
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = shift_dst[AW-1:0];
                    wr_data = rd_entry;
                end
                if (ptr_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    ptr_next  = ptr_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register, loaded from staging once the previous beat is gone
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_entry_next  = res_entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        pend_idx_reg   <= pend_idx_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign hit_address     = out_entry_reg.node_address;
    assign hit_dest_mac    = out_entry_reg.dest_mac;
    assign hit_iface_mac   = out_entry_reg.iface_mac;
    assign hit_iface_index = out_entry_reg.iface_index;

endmodule

@@ rtl/art_ram.sv @@
// generic single write port, single read port ram with registered read
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for the address resolution table: directed command table, then random traffic
module tb_top
    import art_pkg::*;
();

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
    // a remove is the slowest command, so this covers any legal gap between
    // two accepted beats many times over
    localparam int STUCK_LIMIT  = 4000;
    // settle time after the last result, longer than a full table scan
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
    // the random part alternates between filling and draining the table
    localparam int SWEEP_ITEMS  = 48;

    // one result beat: status plus the contents of the matched entry
    typedef struct packed {
        logic [1:0] status;
        entry_t     hit;
    } reply_t;

    // one command beat plus, for table rows, an expected reply typed in by hand
    typedef struct packed {
        logic [1:0] cmd;
        entry_t     req;
        logic       fixed;
        reply_t     reply;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_ADD;
    logic [7:0]  node_address = '0;
    logic [47:0] dest_mac = '0;
    logic [47:0] iface_mac = '0;
    logic [7:0]  iface_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [7:0]  hit_address;
    logic [47:0] hit_dest_mac;
    logic [47:0] hit_iface_mac;
    logic [7:0]  hit_iface_index;

    // travels with the command beat so the accept side knows a hand-typed reply
    logic        row_fixed = 1'b0;
    reply_t      row_reply = '0;

    // shadow copy of the table, kept dense like the block's own
    entry_t      shadow_entries [TABLE_DEPTH];
    int          shadow_count = 0;
    reply_t      pending_replies [$];
    int          mismatch_count = 0;
    int          stuck_cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    always #1 clk = ~clk;

    address_resolution_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (.*);

    // apply one command to the shadow table and return the reply it earns
    function automatic reply_t apply_table_command(input logic [1:0] cmd, input entry_t req);
        reply_t reply;
        int     slot;
        int     i;
        reply = '0;
        slot = -1;
        if (cmd == CMD_ADD)
        begin
            // append at slot count, or refuse when every slot is taken
            if (shadow_count == TABLE_DEPTH)
            begin
                reply.status = STATUS_FULL;
            end
            else
            begin
                shadow_entries[shadow_count] = req;
                shadow_count++;
                reply.status = STATUS_OK;
            end
        end
        else
        begin
            // first match in slot order; duplicates further on are never seen
            for (i = 0; i < shadow_count; i++)
            begin
                if (slot < 0 && ((cmd == CMD_LOOKUP_INDEX)
                        ? shadow_entries[i].iface_index == req.iface_index
                        : shadow_entries[i].node_address == req.node_address))
                begin
                    slot = i;
                end
            end
            if (slot < 0)
            begin
                reply.status = STATUS_NOT_FOUND;
            end
            else
            begin
                reply.status = STATUS_OK;
                reply.hit = shadow_entries[slot];
                if (cmd == CMD_REMOVE)
                begin
                    // close the gap: every later entry moves one slot forward
                    for (i = slot; i < shadow_count - 1; i++)
                    begin
                        shadow_entries[i] = shadow_entries[i + 1];
                    end
                    shadow_count--;
                end
            end
        end
        return reply;
    endfunction

    function automatic row_t directed_row(input logic [1:0] cmd, input logic [7:0] addr,
                                          input logic [47:0] dmac, input logic [47:0] imac,
                                          input logic [7:0] idx, input logic fixed,
                                          input logic [1:0] fixed_status);
        row_t row;
        row.cmd = cmd;
        row.req = {addr, dmac, imac, idx};
        row.fixed = fixed;
        row.reply = '0;
        row.reply.status = fixed_status;
        return row;
    endfunction

    // mostly random MACs, with the all-zero and all-one corners now and then
    function automatic logic [47:0] random_mac();
        logic [31:0] upper_word;
        logic [31:0] lower_word;
        upper_word = $urandom;
        lower_word = $urandom;
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return {upper_word[15:0], lower_word};
        endcase
    endfunction

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // present one command beat, with random idle cycles ahead of it, and
    // return at the edge where it is taken
    task automatic send_beat(input row_t row);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= row.cmd;
        node_address <= row.req.node_address;
        dest_mac     <= row.req.dest_mac;
        iface_mac    <= row.req.iface_mac;
        iface_index  <= row.req.iface_index;
        row_fixed    <= row.fixed;
        row_reply    <= row.reply;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // receiver: stall at random, rate set per phase
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // accept side: predict on every command beat, check every result beat
    always @(posedge clk)
    begin
        reply_t want;
        if (in_valid && in_ready)
        begin
            // the shadow table always advances, even when the reply is hand-typed
            want = apply_table_command(command,
                                       {node_address, dest_mac, iface_mac, iface_index});
            if (row_fixed)
            begin
                want = row_reply;
            end
            pending_replies.push_back(want);
        end
        if (out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: result beat with no command waiting, status %h", $time, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("status", 48'(want.status), 48'(status));
                check_field("hit_address", 48'(want.hit.node_address), 48'(hit_address));
                check_field("hit_dest_mac", want.hit.dest_mac, hit_dest_mac);
                check_field("hit_iface_mac", want.hit.iface_mac, hit_iface_mac);
                check_field("hit_iface_index", 48'(want.hit.iface_index),
                            48'(hit_iface_index));
            end
        end
        // watchdog: cycles with no beat on either channel
        stuck_cycles <= ((in_valid && in_ready) || (out_valid && out_ready))
                        ? 0 : stuck_cycles + 1;
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
        end
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        row_t directed_rows [$];
        row_t row;
        int   k;
        int   phase;
        int   n;
        int   pick;
        bit   draining;

        // empty table: every search misses
        directed_rows.push_back(directed_row(CMD_LOOKUP_ADDR, 8'h00, '0, '0, 8'h00,
                                             1'b1, STATUS_NOT_FOUND));
        directed_rows.push_back(directed_row(CMD_LOOKUP_INDEX, 8'hFF, '0, '0, 8'hFF,
                                             1'b1, STATUS_NOT_FOUND));
        directed_rows.push_back(directed_row(CMD_REMOVE, 8'h80, '0, '0, 8'h80,
                                             1'b1, STATUS_NOT_FOUND));
        // adds at the field extremes, then a duplicate address
        directed_rows.push_back(directed_row(CMD_ADD, 8'h00, '0, '0, 8'h00,
                                             1'b1, STATUS_OK));
        directed_rows.push_back(directed_row(CMD_ADD, 8'hFF, '1, '1, 8'hFF,
                                             1'b1, STATUS_OK));
        directed_rows.push_back(directed_row(CMD_ADD, 8'h00, 48'h0123_4567_89AB,
                                             48'hA5A5_5A5A_C3C3, 8'h5A, 1'b1, STATUS_OK));
        // duplicate address: the oldest entry wins
        directed_rows.push_back(directed_row(CMD_LOOKUP_ADDR, 8'h00, '0, '0, 8'h00,
                                             1'b0, STATUS_OK));
        directed_rows.push_back(directed_row(CMD_LOOKUP_INDEX, 8'h00, '0, '0, 8'hFF,
                                             1'b0, STATUS_OK));
        directed_rows.push_back(directed_row(CMD_LOOKUP_INDEX, 8'h00, '0, '0, 8'h5A,
                                             1'b0, STATUS_OK));
        // remove the head entry, the later ones shift up and the duplicate shows
        directed_rows.push_back(directed_row(CMD_REMOVE, 8'h00, '0, '0, 8'h00,
                                             1'b0, STATUS_OK));
        directed_rows.push_back(directed_row(CMD_LOOKUP_ADDR, 8'h00, '0, '0, 8'h00,
                                             1'b0, STATUS_OK));
        // fill the remaining slots
        for (k = 0; k < TABLE_DEPTH - 2; k++)
        begin
            directed_rows.push_back(directed_row(CMD_ADD, 8'(8'h10 + k),
                                                 {40'h02_0000_0000, 8'(k)},
                                                 {40'hFE_DCBA_9876, 8'(k)}, 8'(k + 1),
                                                 1'b1, STATUS_OK));
        end
        // table full: refused, all hit fields zero
        directed_rows.push_back(directed_row(CMD_ADD, 8'h77, '1, '1, 8'h77,
                                             1'b1, STATUS_FULL));
        directed_rows.push_back(directed_row(CMD_LOOKUP_ADDR, 8'hFF, '0, '0, 8'h00,
                                             1'b0, STATUS_OK));
        // remove of the very last slot: nothing behind it to shift
        directed_rows.push_back(directed_row(CMD_REMOVE, 8'(8'h10 + TABLE_DEPTH - 3),
                                             '0, '0, 8'h00, 1'b0, STATUS_OK));

        // hold reset, then release it on an edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < directed_rows.size(); k++)
        begin
            send_beat(directed_rows[k]);
        end

        // random part, four handshake phases: none, sender idle, receiver
        // stall, and both lightly
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // sweep the count between empty and full: drain first, since
                // the directed part leaves the table nearly full
                draining = (((phase * PHASE_ITEMS + n) / SWEEP_ITEMS) % 2) == 0;
                pick = $urandom_range(0, 99);
                if (pick < (draining ? 10 : 60))
                begin
                    row.cmd = CMD_ADD;
                end
                else if (pick < 75)
                begin
                    row.cmd = CMD_REMOVE;
                end
                else if (pick < 88)
                begin
                    row.cmd = CMD_LOOKUP_ADDR;
                end
                else
                begin
                    row.cmd = CMD_LOOKUP_INDEX;
                end
                // small key pool so searches and removes mostly hit, with
                // full-range keys mixed in
                row.req.node_address = ($urandom_range(0, 3) == 0)
                                       ? 8'($urandom) : 8'($urandom_range(0, 7));
                row.req.dest_mac     = random_mac();
                row.req.iface_mac    = random_mac();
                row.req.iface_index  = ($urandom_range(0, 3) == 0)
                                       ? 8'($urandom) : 8'($urandom_range(0, 7));
                row.fixed = 1'b0;
                row.reply = '0;
                send_beat(row);
            end
        end

        in_valid <= 1'b0;
        // let the last accepted beat reach the prediction queue first
        @(posedge clk);
        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        // catch any stray result beat after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
